// File: hdl/chpx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chpx_pkg: shared types and constants
// Item and result structs, operation codes and charlieplex geometry for the
// charlieplexed LED matrix driver.
// ----------------------------------------------------------------------------
package chpx_pkg;

    localparam int PIN_LINES  = 10;
    localparam int LINE_COUNT = PIN_LINES + 1;
    localparam int STORE_DEPTH = 2 * LINE_COUNT;
    localparam int WORD_W     = LINE_COUNT;
    localparam int LINE_W     = $clog2(LINE_COUNT + 2);
    localparam int ADDR_W     = $clog2(STORE_DEPTH);
    localparam int COL_W      = 5;

    localparam logic [LINE_W-1:0] LAST_LINE = LINE_W'(PIN_LINES);

    localparam logic [1:0] OP_SCAN  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_SWAP  = 2'd3;

    typedef struct packed {
        logic [1:0] operation;
        logic [2:0] pixel_row;
        logic [4:0] pixel_column;
        logic       pixel_value;
    } t_item;

    typedef struct packed {
        logic [7:0] drive_low;
        logic [1:0] drive_high;
        logic [7:0] enable_low;
        logic [1:0] enable_high;
        logic       pixel_read;
    } t_result;

endpackage

// File: hdl/charlieplex_matrix_driver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// charlieplex_matrix_driver: double-buffered charlieplexed LED matrix driver
// 5x18 matrix on 10 tri-state pins; scan ticks, back-buffer pixel writes,
// front-buffer pixel reads and buffer swaps.
// ----------------------------------------------------------------------------
//  channel   | ports                  | transfer
//  ----------+------------------------+-------------------------------
//  item in   | start, busy, i_item    | edge with start high, busy low
//  result    | strobe, o_result       | edge ending the strobe cycle
//
//  One item per cycle; busy stays low. Each item passes through an input
//  register, then one pass through the store lookup into the result register.
//  The frame store is 22 words of flip-flops read at one address per cycle.
//  Synchronous active-low reset loads the one-hot line pattern into both
//  buffers. Results cannot be stalled.
// ----------------------------------------------------------------------------
module charlieplex_matrix_driver (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  chpx_pkg::t_item   i_item,
    output logic              strobe,
    output chpx_pkg::t_result o_result
);

    localparam int LW = chpx_pkg::LINE_W;
    localparam int AW = chpx_pkg::ADDR_W;
    localparam int WW = chpx_pkg::WORD_W;
    localparam int PL = chpx_pkg::PIN_LINES;

    logic [WW-1:0]         r_store [chpx_pkg::STORE_DEPTH];
    logic                  r_front;
    logic [LW-1:0]         r_scan_line;
    logic [2*PL-1:0]       r_pin;
    logic [2*PL-1:0]       n_pin;
    logic                  r_in_valid;
    chpx_pkg::t_item       r_in;
    logic                  r_strobe;
    chpx_pkg::t_result     r_result;

    // pixel folding
    logic [LW-1:0]         loc_line;
    logic [chpx_pkg::COL_W-1:0] loc_bit;
    logic                  loc_ok;
    logic [AW-1:0]         front_base;
    logic [AW-1:0]         back_base;
    logic [AW-1:0]         rd_addr;
    logic [WW-1:0]         rd_word;
    logic [LW-1:0]         sl;
    logic [LW-1:0]         sl_next;
    logic [PL-1:0]         lvl;
    logic                  rd_bit;

    assign busy = 1'b0;

    always_comb begin
        loc_line = {1'b0, r_in.pixel_row};
        loc_bit  = r_in.pixel_column;
        if (r_in.pixel_column < 5'd4) begin
            loc_bit = r_in.pixel_column + 5'd6;
        end else if (r_in.pixel_column < 5'd9) begin
            loc_bit = r_in.pixel_column - 5'd4;
        end else begin
            loc_bit  = (r_in.pixel_column < 5'd13) ? r_in.pixel_column - 5'd3
                                                   : r_in.pixel_column - 5'd13;
            loc_line = {1'b0, r_in.pixel_row} + LW'(5);
        end
        // a bit that lands on its own line moves to bit 5
        if ({1'b0, loc_line} == loc_bit) begin
            loc_bit = 5'd5;
        end
        loc_ok = (loc_line <= chpx_pkg::LAST_LINE) && (loc_bit <= 5'd10);
    end

    assign front_base = r_front ? AW'(chpx_pkg::LINE_COUNT) : '0;
    assign back_base  = r_front ? '0 : AW'(chpx_pkg::LINE_COUNT);
    assign sl         = (r_scan_line > chpx_pkg::LAST_LINE) ? '0 : r_scan_line;
    assign sl_next    = (sl == chpx_pkg::LAST_LINE) ? '0 : sl + LW'(1);
    assign rd_addr    = front_base + AW'(r_in.operation == chpx_pkg::OP_SCAN
                                         ? sl : loc_line);
    assign rd_word    = (rd_addr < AW'(chpx_pkg::STORE_DEPTH)) ? r_store[rd_addr] : '0;
    assign rd_bit     = loc_ok ? rd_word[loc_bit[3:0]] : 1'b0;

    always_comb begin
        lvl = rd_word[PL-1:0] & ~(PL'(1) << sl);
        if (sl == chpx_pkg::LAST_LINE) begin
            lvl = ~lvl;
        end
        n_pin = r_pin;
        if (r_in_valid && r_in.operation == chpx_pkg::OP_SCAN) begin
            n_pin = {rd_word[PL-1:0], lvl};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
        r_in <= i_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < chpx_pkg::STORE_DEPTH; i++) begin
                r_store[i] <= WW'(1) << (i % chpx_pkg::LINE_COUNT);
            end
            r_front     <= 1'b0;
            r_scan_line <= '0;
            r_pin       <= '0;
            r_strobe    <= 1'b0;
            r_result    <= '0;
        end else begin
            r_strobe <= r_in_valid;
            if (r_in_valid) begin
                case (r_in.operation)
                    chpx_pkg::OP_SCAN: begin
                        r_scan_line <= sl_next;
                    end
                    chpx_pkg::OP_WRITE: begin
                        if (loc_ok) begin
                            r_store[back_base + AW'(loc_line)][loc_bit[3:0]]
                                <= r_in.pixel_value;
                        end
                    end
                    chpx_pkg::OP_SWAP: begin
                        r_front <= ~r_front;
                    end
                    default: begin
                    end
                endcase
                r_pin <= n_pin;
                r_result.drive_low   <= n_pin[7:0];
                r_result.drive_high  <= n_pin[9:8];
                r_result.enable_low  <= n_pin[17:10];
                r_result.enable_high <= n_pin[19:18];
                r_result.pixel_read  <= (r_in.operation == chpx_pkg::OP_READ) ? rd_bit
                                                                              : 1'b0;
            end
        end
    end

    assign strobe   = r_strobe;
    assign o_result = r_result;

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid |=> strobe)
        else $error("accepted item produced no result");

    a_line_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scan_line <= chpx_pkg::LAST_LINE)
        else $error("scan line out of range");

    a_pins_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_in.operation != chpx_pkg::OP_SCAN) |=> $stable(r_pin))
        else $error("pins changed on a non-scan item");

    a_read_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_in.operation != chpx_pkg::OP_READ) |=> !o_result.pixel_read)
        else $error("pixel_read set on a non-read item");

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for charlieplex_matrix_driver
// Sends scan, pixel write, pixel read and buffer swap commands with random
// gaps, keeps its own copy of the frame store, buffer select, scan line and
// pin state to predict each result, and checks every strobed result in order.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int RANDOM_ITEMS   = 1200;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WW             = chpx_pkg::WORD_W;
    localparam int PL             = chpx_pkg::PIN_LINES;
    localparam int LC             = chpx_pkg::LINE_COUNT;

    typedef struct {
        chpx_pkg::t_item item;
        bit              hold;    // wait until all results are in before this transfer
    } t_cmd_slot;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start   = 1'b0;
    logic              busy;
    chpx_pkg::t_item   i_item  = '0;
    logic              strobe;
    chpx_pkg::t_result o_result;

    charlieplex_matrix_driver dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .strobe   (strobe),
        .o_result (o_result)
    );

    always #5 i_clk = ~i_clk;

    // predicted block state
    logic [WW-1:0]     frame_mem [chpx_pkg::STORE_DEPTH];
    logic              front_buf;
    logic [3:0]        scan_idx;
    logic [19:0]       pin_state;

    t_cmd_slot         cmd_queue[$];
    chpx_pkg::t_result expected_results[$];
    int        n_sent = 0;
    int        n_got = 0;
    int        errors = 0;
    int        gap_left = 0;
    int        burst_left = 0;
    int        idle_cycles = 0;

    // row/column fold onto line and bit; 0 when the address is outside the store
    function automatic bit pixel_locate(input logic [2:0] row, input logic [4:0] col,
                                        output int line, output int bit_pos);
        int r;
        int c;
        r = row;
        c = col;
        if (c < 4) begin
            c = c + 6;
        end else if (c < 9) begin
            c = c - 4;
        end else begin
            c = (c < 13) ? c - 3 : c - 13;
            r = r + 5;
        end
        if (r == c) c = 5;
        line = r;
        bit_pos = c;
        return (r <= PL) && (c <= WW - 1);
    endfunction

    task automatic predict_result(input chpx_pkg::t_item it);
        int                line;
        int                bit_pos;
        int                sl;
        int                front;
        int                back;
        logic [WW-1:0]     en;
        logic [WW-1:0]     lvl;
        logic              rd;
        chpx_pkg::t_result res;
        front = front_buf ? LC : 0;
        back  = front_buf ? 0 : LC;
        rd    = 1'b0;
        case (it.operation)
            chpx_pkg::OP_SCAN: begin
                sl  = (scan_idx > PL) ? 0 : scan_idx;
                en  = frame_mem[front + sl];
                lvl = en & ~(WW'(1) << sl);
                if (sl == PL) lvl = ~lvl;    // last line drives inverted
                pin_state = {en[PL-1:0], lvl[PL-1:0]};
                scan_idx  = (sl == PL) ? 4'd0 : 4'(sl + 1);
            end
            chpx_pkg::OP_WRITE: begin
                if (pixel_locate(it.pixel_row, it.pixel_column, line, bit_pos))
                    frame_mem[back + line][bit_pos] = it.pixel_value;
            end
            chpx_pkg::OP_READ: begin
                if (pixel_locate(it.pixel_row, it.pixel_column, line, bit_pos))
                    rd = frame_mem[front + line][bit_pos];
            end
            default: begin
                front_buf = ~front_buf;
            end
        endcase
        res.drive_low   = pin_state[7:0];
        res.drive_high  = pin_state[9:8];
        res.enable_low  = pin_state[17:10];
        res.enable_high = pin_state[19:18];
        res.pixel_read  = rd;
        expected_results.push_back(res);
    endtask

    task automatic push_cmd(input logic [1:0] op, input int row, input int col,
                            input bit val, input bit hold);
        t_cmd_slot slot;
        slot.item.operation    = op;
        slot.item.pixel_row    = 3'(row);
        slot.item.pixel_column = 5'(col);
        slot.item.pixel_value  = val;
        slot.hold              = hold;
        cmd_queue.push_back(slot);
    endtask

    // mostly back-to-back, some short gaps, a few long ones, now and then a burst
    function automatic int next_gap();
        int roll;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        roll = $urandom_range(0, 999);
        if (roll < 5) begin
            burst_left = $urandom_range(40, 120);
            return 0;
        end
        if (roll < 600) return 0;
        if (roll < 900) return $urandom_range(1, 3);
        if (roll < 985) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got %0h, want %0h",
                                      n_got, name, got, want));
    endtask

    // driver: predicts each transfer as it is accepted, then loads the next command
    always @(posedge i_clk) begin : driver
        bit        accepted;
        int        outstanding;
        t_cmd_slot slot;
        if (i_rst_n) begin
            accepted = start && !busy;
            if (accepted) begin
                predict_result(i_item);
                n_sent <= n_sent + 1;
            end
            outstanding = n_sent + (accepted ? 1 : 0) - n_got;
            if (start && !accepted) begin
                // held off by busy, keep the item up
            end else if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (cmd_queue.size() == 0) begin
                start <= 1'b0;
            end else if (cmd_queue[0].hold && outstanding != 0) begin
                start <= 1'b0;
            end else begin
                slot = cmd_queue.pop_front();
                i_item   <= slot.item;
                start    <= 1'b1;
                gap_left = next_gap();
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        chpx_pkg::t_result want;
        if (i_rst_n && strobe) begin
            n_got <= n_got + 1;
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("result %0d with nothing expected", n_got));
            end else begin
                want = expected_results.pop_front();
                check_field("drive_low", o_result.drive_low, want.drive_low);
                check_field("drive_high", 8'(o_result.drive_high), 8'(want.drive_high));
                check_field("enable_low", o_result.enable_low, want.enable_low);
                check_field("enable_high", 8'(o_result.enable_high), 8'(want.enable_high));
                check_field("pixel_read", 8'(o_result.pixel_read), 8'(want.pixel_read));
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (i_rst_n) begin
            if ((start && !busy) || strobe) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("charlieplex_matrix_driver: mismatch");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin : stimulus
        int  roll;
        bit  in_range;
        logic [1:0] op;
        for (int i = 0; i < LC; i++) begin
            frame_mem[i]      = WW'(1) << i;
            frame_mem[LC + i] = WW'(1) << i;
        end
        front_buf = 1'b0;
        scan_idx  = '0;
        pin_state = '0;

        // directed: fold corners, diagonal remap, out-of-store and out-of-range
        push_cmd(chpx_pkg::OP_READ, 0, 4, 1'b1, 1'b0);      // bit equals line -> bit 5
        push_cmd(chpx_pkg::OP_READ, 0, 0, 1'b0, 1'b0);
        push_cmd(chpx_pkg::OP_WRITE, 4, 17, 1'b1, 1'b0);
        push_cmd(chpx_pkg::OP_WRITE, 0, 4, 1'b1, 1'b0);
        push_cmd(chpx_pkg::OP_WRITE, 7, 31, 1'b1, 1'b0);    // outside the store, ignored
        push_cmd(chpx_pkg::OP_WRITE, 5, 0, 1'b1, 1'b0);     // row out of range, still stored
        push_cmd(chpx_pkg::OP_WRITE, 7, 12, 1'b1, 1'b0);    // line 12, ignored
        push_cmd(chpx_pkg::OP_WRITE, 3, 9, 1'b0, 1'b0);
        push_cmd(chpx_pkg::OP_SWAP, 0, 0, 1'b0, 1'b1);
        push_cmd(chpx_pkg::OP_READ, 4, 17, 1'b0, 1'b0);
        push_cmd(chpx_pkg::OP_READ, 0, 4, 1'b0, 1'b0);
        push_cmd(chpx_pkg::OP_READ, 5, 0, 1'b0, 1'b0);
        push_cmd(chpx_pkg::OP_READ, 7, 31, 1'b0, 1'b0);
        for (int i = 0; i < LC + 1; i++)  // full frame plus wrap
            push_cmd(chpx_pkg::OP_SCAN, 0, 0, 1'b0, 1'b0);
        push_cmd(chpx_pkg::OP_SWAP, 7, 31, 1'b1, 1'b0);
        push_cmd(chpx_pkg::OP_READ, 2, 8, 1'b0, 1'b0);
        push_cmd(chpx_pkg::OP_READ, 7, 3, 1'b0, 1'b0);

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            roll = $urandom_range(0, 99);
            op = (roll < 35) ? chpx_pkg::OP_SCAN : (roll < 70) ? chpx_pkg::OP_WRITE :
                 (roll < 90) ? chpx_pkg::OP_READ : chpx_pkg::OP_SWAP;
            in_range = ($urandom_range(0, 9) < 8);
            if (in_range)
                push_cmd(op, $urandom_range(0, 4), $urandom_range(0, 17),
                         1'($urandom), ($urandom_range(0, 99) == 0));
            else
                push_cmd(op, $urandom_range(0, 7), $urandom_range(0, 31),
                         1'($urandom), ($urandom_range(0, 99) == 0));
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sample between edges so the driver and monitor have settled
        do @(negedge i_clk);
        while (cmd_queue.size() != 0 || start || n_sent != n_got);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (errors == 0) begin
            $display("charlieplex_matrix_driver: match");
        end else begin
            $display("charlieplex_matrix_driver: mismatch");
        end
        $finish;
    end

endmodule
